>>> src/isac_pkg.sv
// shared types and constants for the ip subnet acl classifier
// no dependencies
package isac_pkg;

    localparam logic [1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [1:0] CMD_WR_ADDR  = 2'd1;
    localparam logic [1:0] CMD_WR_NET   = 2'd2;
    localparam logic [1:0] CMD_NOP      = 2'd3;

    localparam logic [1:0] KIND_BLACK   = 2'd0;
    localparam logic [1:0] KIND_WHITE   = 2'd1;
    localparam logic [1:0] KIND_NEITHER = 2'd2;

    localparam logic [1:0] ACT_PASS     = 2'd0;
    localparam logic [1:0] ACT_DROP     = 2'd1;
    localparam logic [1:0] ACT_REDIRECT = 2'd2;

    localparam logic [1:0] VERDICT_BLACK = 2'd0;
    localparam logic [1:0] VERDICT_WHITE = 2'd1;
    localparam logic [1:0] VERDICT_NONE  = 2'd3;

    localparam logic [1:0] REG_BLOCK_SOURCE = 2'd0;
    localparam logic [1:0] REG_REDIRECT     = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR_SCAN,
        ST_NET_WALK,
        ST_ADDR_WRITE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic addr_write;
        logic net_write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic addr_done;
        logic addr_hit;
        logic net_done;
    } ctrl_status_t;

endpackage

>>> src/isac_if.sv
// valid/ready channel interfaces for requests and results
// depends on nothing
interface isac_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] pkt_src;
    logic        has_ipv4;
    logic        is_tcp;
    logic [1:0]  entry_type;
    logic [7:0]  subnet_slot;
    logic [31:0] net_address;
    logic [31:0] net_mask;
    modport source (output valid, cmd, pkt_src, has_ipv4, is_tcp, entry_type,
                    subnet_slot, net_address, net_mask, input ready);
    modport sink (input valid, cmd, pkt_src, has_ipv4, is_tcp, entry_type,
                  subnet_slot, net_address, net_mask, output ready);
endinterface

interface isac_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] new_destination;
    logic        report_to_host;
    modport source (output valid, action, new_destination, report_to_host, input ready);
    modport sink (input valid, action, new_destination, report_to_host, output ready);
endinterface

>>> src/isac_ctrl.sv
// controller state machine sequencing table scans and writes
// depends on isac_pkg
module isac_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic [1:0]            req_cmd,
    input  logic                  req_has_ipv4,
    input  logic                  res_ready,
    output logic                  req_ready,
    output logic                  res_valid,
    output isac_pkg::ctrl_cmd_t   ctrl,
    input  isac_pkg::ctrl_status_t status
);
    import isac_pkg::*;

    state_t state_reg, state_next;
    logic   classify_reg, classify_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            classify_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            classify_reg <= classify_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        classify_next = classify_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_cmd)
                        CMD_CLASSIFY:
                        begin
                            classify_next = 1'b1;
                            state_next = req_has_ipv4 ? ST_ADDR_SCAN : ST_RESULT;
                        end
                        CMD_WR_ADDR:
                        begin
                            classify_next = 1'b0;
                            state_next = ST_ADDR_SCAN;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADDR_SCAN:
            begin
                if (status.addr_done)
                begin
                    if (!classify_reg)
                        state_next = ST_ADDR_WRITE;
                    else if (status.addr_hit)
                        state_next = ST_RESULT;
                    else
                        state_next = ST_NET_WALK;
                end
            end
            ST_NET_WALK:
            begin
                if (status.net_done)
                    state_next = ST_RESULT;
            end
            ST_ADDR_WRITE:
                state_next = ST_IDLE;
            ST_RESULT:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        ctrl            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                ctrl.start = req_valid;
                ctrl.net_write = req_valid && (req_cmd == CMD_WR_NET);
            end
            ST_ADDR_SCAN:
                ctrl.step = !status.addr_done;
            ST_NET_WALK:
                ctrl.step = 1'b1;
            ST_ADDR_WRITE:
                ctrl.addr_write = 1'b1;
            ST_RESULT:
                res_valid = 1'b1;
            default:
                ctrl = '0;
        endcase
    end

endmodule

>>> src/isac_datapath.sv
// datapath: address and subnet memories, scan pointer, verdict logic
// depends on isac_pkg
module isac_datapath #(
    parameter int ADDR_ENTRIES   = 256,
    parameter int SUBNET_ENTRIES = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isac_pkg::ctrl_cmd_t    ctrl,
    output isac_pkg::ctrl_status_t status,
    input  logic [1:0]             in_cmd,
    input  logic [31:0]            in_pkt_src,
    input  logic                   in_has_ipv4,
    input  logic                   in_is_tcp,
    input  logic [1:0]             in_entry_type,
    input  logic [7:0]             in_subnet_slot,
    input  logic [31:0]            in_net_address,
    input  logic [31:0]            in_net_mask,
    input  logic                   block_source,
    input  logic [31:0]            redirect_address,
    output logic [1:0]             action,
    output logic [31:0]            new_destination,
    output logic                   report_to_host
);
    import isac_pkg::*;

    localparam int AW = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
    localparam int NW = (SUBNET_ENTRIES > 1) ? $clog2(SUBNET_ENTRIES) : 1;
    localparam int AC = $clog2(ADDR_ENTRIES + 1);
    localparam int NC = $clog2(SUBNET_ENTRIES + 1);

    logic [31:0] addr_keys [ADDR_ENTRIES];
    logic        addr_black [ADDR_ENTRIES];
    logic [ADDR_ENTRIES-1:0] addr_valid_reg;
    logic [65:0] net_mem [SUBNET_ENTRIES];
    logic [SUBNET_ENTRIES-1:0] net_valid_reg;

    logic [31:0] key_reg;
    logic        tcp_reg;
    logic        ipv4_reg;
    logic [1:0]  etype_reg;
    logic [AC-1:0] aptr_reg;
    logic [NC-1:0] nptr_reg;
    logic        rd_pend_reg;
    logic [31:0] rd_key_reg;
    logic        rd_black_reg;
    logic        rd_valid_reg;
    logic [65:0] rd_net_reg;
    logic        addr_done_reg, addr_hit_reg, net_done_reg;
    logic [AW-1:0] hit_idx_reg;
    logic        free_found_reg;
    logic [AW-1:0] free_idx_reg;
    logic [1:0]  verdict_reg;

    logic        a_match, n_match;
    logic [AW-1:0] rd_aidx;
    logic [31:0] n_mask;

    assign rd_aidx = aptr_reg[AW-1:0] - AW'(1);
    assign a_match = rd_valid_reg && (rd_key_reg == key_reg);
    assign n_mask  = rd_net_reg[33:2];
    assign n_match = (key_reg & n_mask) == (rd_net_reg[65:34] & n_mask);

    // memories
    always_ff @(posedge clk)
    begin
        if (ctrl.addr_write)
        begin
            if (addr_hit_reg)
                addr_black[hit_idx_reg] <= (etype_reg == KIND_BLACK);
            else if (free_found_reg)
            begin
                addr_keys[free_idx_reg]  <= key_reg;
                addr_black[free_idx_reg] <= (etype_reg == KIND_BLACK);
            end
        end
        if (ctrl.net_write && (32'(in_subnet_slot) < 32'(SUBNET_ENTRIES)))
            net_mem[NW'(in_subnet_slot)] <= {in_net_address, in_net_mask, in_entry_type};
        if (aptr_reg < AC'(ADDR_ENTRIES))
        begin
            rd_key_reg   <= addr_keys[aptr_reg[AW-1:0]];
            rd_black_reg <= addr_black[aptr_reg[AW-1:0]];
        end
        if (nptr_reg < NC'(SUBNET_ENTRIES))
            rd_net_reg <= net_mem[nptr_reg[NW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_valid_reg <= '0;
            net_valid_reg  <= '0;
            aptr_reg       <= '0;
            nptr_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            addr_done_reg  <= 1'b0;
            addr_hit_reg   <= 1'b0;
            net_done_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            verdict_reg    <= VERDICT_NONE;
        end
        else
        begin
            if (ctrl.net_write && (32'(in_subnet_slot) < 32'(SUBNET_ENTRIES)))
                net_valid_reg[NW'(in_subnet_slot)] <= 1'b1;
            if (ctrl.addr_write && !addr_hit_reg && free_found_reg)
                addr_valid_reg[free_idx_reg] <= 1'b1;
            if (ctrl.start)
            begin
                aptr_reg       <= '0;
                nptr_reg       <= '0;
                rd_pend_reg    <= 1'b0;
                addr_done_reg  <= 1'b0;
                addr_hit_reg   <= 1'b0;
                net_done_reg   <= 1'b0;
                free_found_reg <= 1'b0;
                verdict_reg    <= VERDICT_NONE;
            end
            else if (ctrl.step && !addr_done_reg)
            begin
                // address scan: issue read, compare registered data
                if (aptr_reg < AC'(ADDR_ENTRIES))
                begin
                    rd_valid_reg <= addr_valid_reg[aptr_reg[AW-1:0]];
                    aptr_reg     <= aptr_reg + AC'(1);
                end
                rd_pend_reg <= aptr_reg < AC'(ADDR_ENTRIES);
                if (rd_pend_reg)
                begin
                    if (a_match)
                    begin
                        addr_hit_reg  <= 1'b1;
                        addr_done_reg <= 1'b1;
                        hit_idx_reg   <= rd_aidx;
                        verdict_reg   <= rd_black_reg ? VERDICT_BLACK : VERDICT_WHITE;
                    end
                    else
                    begin
                        if (!rd_valid_reg && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= rd_aidx;
                        end
                        if (aptr_reg == AC'(ADDR_ENTRIES))
                        begin
                            addr_done_reg <= 1'b1;
                            rd_pend_reg   <= 1'b0;
                        end
                    end
                end
            end
            else if (ctrl.step && !net_done_reg)
            begin
                // subnet walk
                if (!rd_pend_reg)
                begin
                    if (nptr_reg == NC'(SUBNET_ENTRIES)
                        || !net_valid_reg[nptr_reg[NW-1:0]])
                        net_done_reg <= 1'b1;
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        nptr_reg    <= nptr_reg + NC'(1);
                    end
                end
                else
                begin
                    rd_pend_reg <= 1'b0;
                    if (n_match)
                    begin
                        net_done_reg <= 1'b1;
                        verdict_reg  <= (rd_net_reg[1:0] == KIND_BLACK
                                         || rd_net_reg[1:0] == KIND_WHITE)
                                        ? rd_net_reg[1:0] : VERDICT_NONE;
                    end
                end
            end
        end
    end

    // request payload capture
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            key_reg   <= in_pkt_src;
            tcp_reg   <= in_is_tcp;
            ipv4_reg  <= in_has_ipv4 && (in_cmd == CMD_CLASSIFY);
            etype_reg <= in_entry_type;
        end
    end

    assign status.addr_done = addr_done_reg;
    assign status.addr_hit  = addr_hit_reg;
    assign status.net_done  = net_done_reg;

    always_comb
    begin
        action          = ACT_PASS;
        new_destination = '0;
        report_to_host  = 1'b0;
        if (ipv4_reg)
        begin
            case (verdict_reg)
                VERDICT_BLACK:
                begin
                    if (block_source)
                        action = ACT_DROP;
                    else
                    begin
                        action          = ACT_REDIRECT;
                        new_destination = redirect_address;
                    end
                end
                VERDICT_NONE:
                    report_to_host = tcp_reg;
                default:
                    action = ACT_PASS;
            endcase
        end
    end

endmodule

>>> src/ip_subnet_acl_classifier.sv
// top level of the ip subnet acl classifier: apb registers, controller, datapath
// depends on isac_pkg, isac_if, isac_ctrl, isac_datapath
//
// One request at a time. An address-entry write scans the address table until
// it finds the key or reaches the end, then writes; a subnet write is done from
// the idle state without a scan. A classify request scans the address table, one
// entry a cycle through a registered memory read, and on a miss walks the subnet
// list, reading each entry and then comparing it. Packets without IPv4 skip the
// scans and go straight to the result. Memories need no clearing pass; valid
// bits clear at reset.
module ip_subnet_acl_classifier #(
    parameter int ADDR_ENTRIES   = 256,
    parameter int SUBNET_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    isac_req_if.sink    req,
    isac_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import isac_pkg::*;

    ctrl_cmd_t    ctrl;
    ctrl_status_t status;
    logic         block_source_reg;
    logic [31:0]  redirect_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_source_reg <= 1'b1;
            redirect_reg     <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_REDIRECT[0])
                redirect_reg <= pwdata;
            else
                block_source_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_REDIRECT[0])
            prdata = redirect_reg;
        else
            prdata = {31'd0, block_source_reg};
    end

    isac_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_cmd      (req.cmd),
        .req_has_ipv4 (req.has_ipv4),
        .res_ready    (res.ready),
        .req_ready    (req.ready),
        .res_valid    (res.valid),
        .ctrl         (ctrl),
        .status       (status)
    );

    isac_datapath #(
        .ADDR_ENTRIES   (ADDR_ENTRIES),
        .SUBNET_ENTRIES (SUBNET_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .status           (status),
        .in_cmd           (req.cmd),
        .in_pkt_src       (req.pkt_src),
        .in_has_ipv4      (req.has_ipv4),
        .in_is_tcp        (req.is_tcp),
        .in_entry_type    (req.entry_type),
        .in_subnet_slot   (req.subnet_slot),
        .in_net_address   (req.net_address),
        .in_net_mask      (req.net_mask),
        .block_source     (block_source_reg),
        .redirect_address (redirect_reg),
        .action           (res.action),
        .new_destination  (res.new_destination),
        .report_to_host   (res.report_to_host)
    );

endmodule
